[rtl/bdpc_pkg.sv]
package bdpc_pkg;

   localparam int DEBOUNCE_W = 8;
   localparam int HELD_W     = 16;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 2;

   localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 8'd6;
   localparam logic [HELD_W-1:0]     LONG_RESET     = 16'd80;

   localparam logic [CSR_IDX_W-1:0] CSR_SETTLE_SAMPLES   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_PRESS_TICKS = 2'd1;

   typedef enum logic [1:0] {
      MODE_OFF     = 2'd0,
      MODE_PRESSED = 2'd1,
      MODE_LONG    = 2'd2
   } mode_type;

   typedef logic [1:0] event_type;

   localparam event_type EVT_NONE  = 2'd0;
   localparam event_type EVT_SHORT = 2'd1;
   localparam event_type EVT_LONG  = 2'd2;

endpackage

[rtl/bdpc_if.sv]
interface bdpc_req_if;
   logic valid;
   logic ready;
   logic button_raw;

   modport source (output valid, output button_raw, input ready);
   modport sink (input valid, input button_raw, output ready);
endinterface

interface bdpc_rsp_if;
   logic                valid;
   logic                ready;
   bdpc_pkg::event_type press_event;
   logic                debounced_level;

   modport source (output valid, output press_event, output debounced_level, input ready);
   modport sink (input valid, input press_event, input debounced_level, output ready);
endinterface

[rtl/bdpc_debounce.sv]
module bdpc_debounce (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 step,
   input  logic                                 sample,
   input  logic [bdpc_pkg::DEBOUNCE_W-1:0]      settle_samples,
   output logic                                 level
);
   import bdpc_pkg::*;

   logic                  stable_ff;
   logic                  stable_in;
   logic [DEBOUNCE_W-1:0] count_ff;
   logic [DEBOUNCE_W-1:0] count_in;
   logic [DEBOUNCE_W-1:0] count_inc;

   // The counter saturates rather than wrapping.
   assign count_inc = (count_ff == {DEBOUNCE_W{1'b1}}) ? count_ff
                                                        : count_ff + DEBOUNCE_W'(1);

   always_comb begin
      stable_in = stable_ff;
      count_in  = count_ff;
      if (sample == stable_ff) begin
         count_in = '0;
      end else if (count_inc >= settle_samples) begin
         stable_in = sample;
         count_in  = '0;
      end else begin
         count_in = count_inc;
      end
   end

   assign level = stable_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         stable_ff <= 1'b0;
         count_ff  <= '0;
      end else if (step) begin
         stable_ff <= stable_in;
         count_ff  <= count_in;
      end
   end

endmodule

[rtl/bdpc_classify.sv]
module bdpc_classify (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             step,
   input  logic                             level,
   input  logic [bdpc_pkg::HELD_W-1:0]      long_press_ticks,
   output bdpc_pkg::event_type              press_event
);
   import bdpc_pkg::*;

   mode_type          mode_ff;
   mode_type          mode_in;
   logic [HELD_W-1:0] held_ff;
   logic [HELD_W-1:0] held_in;
   logic [HELD_W-1:0] held_inc;
   logic              long_reached;

   assign held_inc     = (held_ff == {HELD_W{1'b1}}) ? held_ff : held_ff + HELD_W'(1);
   assign long_reached = held_inc >= long_press_ticks;

   always_comb begin
      case (mode_ff)
         MODE_PRESSED: begin
            if (!level) begin
               mode_in = MODE_OFF;
            end else if (long_reached) begin
               mode_in = MODE_LONG;
            end else begin
               mode_in = MODE_PRESSED;
            end
         end
         MODE_LONG: begin
            mode_in = level ? MODE_LONG : MODE_OFF;
         end
         default: begin
            mode_in = level ? MODE_PRESSED : MODE_OFF;
         end
      endcase
   end

   always_comb begin
      press_event = EVT_NONE;
      held_in     = held_ff;
      case (mode_ff)
         MODE_PRESSED: begin
            if (!level) begin
               press_event = EVT_SHORT;
            end else begin
               held_in = held_inc;
               if (long_reached) begin
                  press_event = EVT_LONG;
               end
            end
         end
         MODE_LONG: begin
            held_in = held_ff;
         end
         default: begin
            // The held count restarts on the tick the press is first seen.
            if (level) begin
               held_in = '0;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_OFF;
         held_ff <= '0;
      end else if (step) begin
         mode_ff <= mode_in;
         held_ff <= held_in;
      end
   end

endmodule

[rtl/button_debounce_press_classifier.sv]
// Each request beat is one poll tick carrying the raw button sample, and each
// produces exactly one response beat with the press event (none, short press
// released, long press reached) and the debounced level after that tick. A
// beat passes an input register and then a result register before its
// response is offered; one beat is taken every cycle while the response side
// keeps up, since the debounce and press-state update is combinational logic
// between the two registers. The user must write registers through the csr
// port only while no beat is in flight; the block does not enforce this:
// index 0 is the count of consecutive differing samples that settles a new
// level (reset 6), index 1 is long_press_ticks (reset 80); other indexes are
// ignored.
module button_debounce_press_classifier (
   input  logic                               clock,
   input  logic                               reset,
   bdpc_req_if.sink                           req_chan,
   bdpc_rsp_if.source                         rsp_chan,
   input  logic                               csr_we,
   input  logic [bdpc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bdpc_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import bdpc_pkg::*;

   logic [DEBOUNCE_W-1:0] settle_samples_ff;
   logic [HELD_W-1:0]     long_press_ticks_ff;

   logic      in_valid_ff;
   logic      in_sample_ff;
   logic      out_valid_ff;
   event_type out_event_ff;
   logic      out_level_ff;

   logic      step;
   logic      level;
   event_type press_event;

   // The staged sample moves on when the result register is free or draining.
   assign step           = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || step;

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_samples_ff   <= DEBOUNCE_RESET;
         long_press_ticks_ff <= LONG_RESET;
      end else if (csr_we) begin
         if (csr_index == CSR_SETTLE_SAMPLES) begin
            settle_samples_ff <= csr_wdata[DEBOUNCE_W-1:0];
         end else if (csr_index == CSR_LONG_PRESS_TICKS) begin
            long_press_ticks_ff <= csr_wdata[HELD_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_sample_ff <= req_chan.button_raw;
      end
   end

   bdpc_debounce u_debounce (
      .clock          (clock),
      .reset          (reset),
      .step           (step),
      .sample         (in_sample_ff),
      .settle_samples (settle_samples_ff),
      .level          (level)
   );

   bdpc_classify u_classify (
      .clock            (clock),
      .reset            (reset),
      .step             (step),
      .level            (level),
      .long_press_ticks (long_press_ticks_ff),
      .press_event      (press_event)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp_chan.ready) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         out_event_ff <= press_event;
         out_level_ff <= level;
      end
   end

   assign rsp_chan.valid           = out_valid_ff;
   assign rsp_chan.press_event     = out_event_ff;
   assign rsp_chan.debounced_level = out_level_ff;

endmodule
